// ===== hdl/twcr_pkg.sv =====
// ----------------------------------------------------------------------------
// twcr_pkg
// Shared widths, codes and grid constants of the tile wall collision resolver.
// ----------------------------------------------------------------------------
package twcr_pkg;

   // grid geometry
   localparam int GRID_COLS = 32;
   localparam int GRID_ROWS = 32;
   localparam int CELLS     = GRID_COLS * GRID_ROWS;
   localparam int IDX_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

   // field widths
   localparam int CELL_W  = 10;
   localparam int POS_W   = 16;
   localparam int SIZE_W  = 15;
   localparam int TILE_W  = 12;
   localparam int MARG_W  = 11;

   // internal geometry width: covers tile edges of the 32 column grid and
   // moved box edges with headroom for the push-back sums
   localparam int GEO_W = 22;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SIZE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_MARGIN = 1'b1;

   localparam logic [TILE_W-1:0] TILE_SIZE_RESET     = 12'd512;
   localparam logic [MARG_W-1:0] SHRINK_MARGIN_RESET = 11'd128;

   // item opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

endpackage

// ===== hdl/twcr_if.sv =====
// ----------------------------------------------------------------------------
// twcr_if
// Valid/ready channels of the tile wall collision resolver: request beats,
// response beats and configuration writes.
// ----------------------------------------------------------------------------
interface twcr_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      op;
   logic        [twcr_pkg::CELL_W-1:0]        cell_index;
   logic                                      is_wall;
   logic signed [twcr_pkg::POS_W-1:0]         box_left;
   logic signed [twcr_pkg::POS_W-1:0]         box_top;
   logic        [twcr_pkg::SIZE_W-1:0]        box_width;
   logic        [twcr_pkg::SIZE_W-1:0]        box_height;
   logic signed [twcr_pkg::POS_W-1:0]         move_x;
   logic signed [twcr_pkg::POS_W-1:0]         move_y;

   modport source (output valid, op, cell_index, is_wall, box_left, box_top,
                   box_width, box_height, move_x, move_y, input ready);
   modport sink   (input valid, op, cell_index, is_wall, box_left, box_top,
                   box_width, box_height, move_x, move_y, output ready);
endinterface

interface twcr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [twcr_pkg::POS_W-1:0] fixed_x;
   logic signed [twcr_pkg::POS_W-1:0] fixed_y;
   logic                              hit;

   modport source (output valid, fixed_x, fixed_y, hit, input ready);
   modport sink   (input valid, fixed_x, fixed_y, hit, output ready);
endinterface

interface twcr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [twcr_pkg::CSR_IDX_W-1:0]      index;
   logic [twcr_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/tile_wall_collision_resolve_unit.sv =====
// ----------------------------------------------------------------------------
// tile_wall_collision_resolve_unit
// Wall tile map with a scanning box-versus-tile push-back resolver.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  : request beats. op = write stores is_wall at cell_index (cells
//              past the grid are dropped); op = query resolves move_x/move_y
//              of the box against every wall tile.
//   rsp_bus  : one response beat per request beat, in order. Writes answer
//              fixed_x = fixed_y = 0, hit = 0.
//   csr_bus  : writes tile_size (index 0) and shrink_margin (index 1); always
//              ready. Write only while no request is in flight.
// Sequencing:
//   A write's response is valid the cycle after the beat.
//   A query passes a load step, then scans the wall map one cell per cycle
//   in row-major order. Each overlapping wall tile holds the scan for a
//   push-back step and a step to move the box again; a done step then waits
//   for the output register. One item is handled at a time.
// Reset:
//   Synchronous, active high. After reset a clearing pass writes every cell
//   of the map to zero; req_bus.ready stays low until it ends.
// Stall:
//   The response is held in an output register until taken. A new request
//   beat is taken while that register is free or being drained; a finished
//   query waits for it.
// ----------------------------------------------------------------------------
module tile_wall_collision_resolve_unit (
   input logic         clock,
   input logic         reset,
   twcr_req_if.sink    req_bus,
   twcr_rsp_if.source  rsp_bus,
   twcr_csr_if.sink    csr_bus
);

   localparam int IdxW  = twcr_pkg::IDX_W;
   localparam int ColW  = twcr_pkg::COL_W;
   localparam int GeoW  = twcr_pkg::GEO_W;
   localparam int PosW  = twcr_pkg::POS_W;
   localparam int SizeW = twcr_pkg::SIZE_W;
   localparam int CellW = twcr_pkg::CELL_W;

   localparam logic [IdxW-1:0] LastIdx = IdxW'(twcr_pkg::CELLS - 1);
   localparam logic [ColW-1:0] LastCol = ColW'(twcr_pkg::GRID_COLS - 1);
   localparam logic signed [GeoW-1:0] SatMax = GeoW'(32767);
   localparam logic signed [GeoW-1:0] SatMin = -(GeoW'(32768));

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_SCAN  = 7'b0001000,
      ST_PUSH  = 7'b0010000,
      ST_UPD   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   function automatic logic signed [PosW-1:0] sat16(input logic signed [GeoW-1:0] v);
      if (v > SatMax) begin
         return PosW'(SatMax);
      end
      if (v < SatMin) begin
         return PosW'(SatMin);
      end
      return PosW'(v);
   endfunction

   // push one axis of the displacement out of the tile span [lo, hi)
   function automatic logic signed [PosW-1:0] push_axis(
      input logic signed [PosW-1:0] d,
      input logic signed [GeoW-1:0] lo,
      input logic signed [GeoW-1:0] hi,
      input logic signed [GeoW-1:0] blo,
      input logic signed [GeoW-1:0] bhi
   );
      logic signed [GeoW-1:0] d_w;
      d_w = GeoW'(d);
      if (d < 0) begin
         return sat16(d_w + (hi - blo));
      end
      if (d > 0) begin
         return sat16(d_w - (bhi - lo));
      end
      return d;
   endfunction

   // control and configuration registers
   state_type                      state_ff, state_in;
   logic [IdxW-1:0]                idx_ff, idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [twcr_pkg::TILE_W-1:0]    tile_ff, tile_in;
   logic [twcr_pkg::MARG_W-1:0]    margin_ff, margin_in;

   // query payload registers
   logic signed [PosW-1:0]         left_ff, left_in;
   logic signed [PosW-1:0]         top_ff, top_in;
   logic [SizeW-1:0]               width_ff, width_in;
   logic [SizeW-1:0]               height_ff, height_in;
   logic signed [PosW-1:0]         dx_ff, dx_in;
   logic signed [PosW-1:0]         dy_ff, dy_in;
   logic                           hit_ff, hit_in;
   logic                           box_ok_ff, box_ok_in;
   logic                           tile_ok_ff, tile_ok_in;
   logic [ColW-1:0]                col_ff, col_in;
   logic signed [GeoW-1:0]         nl_ff, nl_in, nr_ff, nr_in;
   logic signed [GeoW-1:0]         nt_ff, nt_in, nb_ff, nb_in;
   logic signed [GeoW-1:0]         tl_ff, tl_in, tr_ff, tr_in;
   logic signed [GeoW-1:0]         tt_ff, tt_in, tb_ff, tb_in;
   logic signed [PosW-1:0]         out_x_ff, out_x_in;
   logic signed [PosW-1:0]         out_y_ff, out_y_in;
   logic                           out_hit_ff, out_hit_in;

   // wall map
   logic                           wall_mem [twcr_pkg::CELLS];
   logic                           rdata_ff;
   logic                           mem_we, mem_wdata, mem_re;
   logic [IdxW-1:0]                mem_waddr, mem_raddr;

   logic signed [GeoW-1:0]         ts_w, mg_w, inner_w;
   logic signed [GeoW-1:0]         w_ext, h_ext;
   logic                           req_fire, last_cell, overlap, in_range;
   logic [IdxW+CellW-1:0]          cell_wide;

   assign ts_w    = signed'(GeoW'(tile_ff));
   assign mg_w    = signed'(GeoW'(margin_ff));
   assign inner_w = ts_w - (mg_w <<< 1);
   assign w_ext   = signed'(GeoW'(width_ff));
   assign h_ext   = signed'(GeoW'(height_ff));

   assign req_bus.ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready   = 1'b1;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.fixed_x = out_x_ff;
   assign rsp_bus.fixed_y = out_y_ff;
   assign rsp_bus.hit     = out_hit_ff;

   assign cell_wide = (IdxW + CellW)'(req_bus.cell_index);
   assign in_range  = cell_wide < (IdxW + CellW)'(twcr_pkg::CELLS);
   assign last_cell = (idx_ff == LastIdx);

   // strict overlap of the moved box and the shrunk tile of the cell in rdata_ff
   assign overlap = rdata_ff && box_ok_ff && tile_ok_ff &&
                    (nl_ff < tr_ff) && (tl_ff < nr_ff) &&
                    (nt_ff < tb_ff) && (tt_ff < nb_ff);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      tile_in      = tile_ff;
      margin_in    = margin_ff;
      left_in      = left_ff;
      top_in       = top_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      hit_in       = hit_ff;
      box_ok_in    = box_ok_ff;
      tile_ok_in   = tile_ok_ff;
      col_in       = col_ff;
      nl_in        = nl_ff;
      nr_in        = nr_ff;
      nt_in        = nt_ff;
      nb_in        = nb_ff;
      tl_in        = tl_ff;
      tr_in        = tr_ff;
      tt_in        = tt_ff;
      tb_in        = tb_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_hit_in   = out_hit_ff;
      mem_we       = 1'b0;
      mem_wdata    = 1'b0;
      mem_waddr    = idx_ff;
      mem_re       = 1'b0;
      mem_raddr    = idx_ff + IdxW'(1);

      // configuration writes
      if (csr_bus.valid) begin
         case (csr_bus.index)
            twcr_pkg::CSR_TILE_SIZE: begin
               tile_in = csr_bus.data[twcr_pkg::TILE_W-1:0];
            end
            twcr_pkg::CSR_SHRINK_MARGIN: begin
               margin_in = csr_bus.data[twcr_pkg::MARG_W-1:0];
            end
            default: begin
            end
         endcase
      end

      // drain the response register
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = 1'b0;
            mem_waddr = idx_ff;
            idx_in    = idx_ff + IdxW'(1);
            if (last_cell) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.op == twcr_pkg::OP_WRITE) begin
                  mem_we       = in_range;
                  mem_wdata    = req_bus.is_wall;
                  mem_waddr    = cell_wide[IdxW-1:0];
                  rsp_valid_in = 1'b1;
                  out_x_in     = '0;
                  out_y_in     = '0;
                  out_hit_in   = 1'b0;
               end else begin
                  left_in   = req_bus.box_left;
                  top_in    = req_bus.box_top;
                  width_in  = req_bus.box_width;
                  height_in = req_bus.box_height;
                  dx_in     = req_bus.move_x;
                  dy_in     = req_bus.move_y;
                  state_in  = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            // place the moved box, prime the first cell read
            nl_in      = GeoW'(left_ff) + GeoW'(dx_ff);
            nr_in      = GeoW'(left_ff) + GeoW'(dx_ff) + w_ext;
            nt_in      = GeoW'(top_ff) + GeoW'(dy_ff);
            nb_in      = GeoW'(top_ff) + GeoW'(dy_ff) + h_ext;
            box_ok_in  = (width_ff != '0) && (height_ff != '0);
            tile_ok_in = inner_w > 0;
            hit_in     = 1'b0;
            idx_in     = '0;
            col_in     = '0;
            tl_in      = mg_w;
            tr_in      = ts_w - mg_w;
            tt_in      = mg_w;
            tb_in      = ts_w - mg_w;
            mem_re     = 1'b1;
            mem_raddr  = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN, ST_UPD: begin
            if (state_ff == ST_UPD) begin
               nl_in = GeoW'(left_ff) + GeoW'(dx_ff);
               nr_in = GeoW'(left_ff) + GeoW'(dx_ff) + w_ext;
               nt_in = GeoW'(top_ff) + GeoW'(dy_ff);
               nb_in = GeoW'(top_ff) + GeoW'(dy_ff) + h_ext;
            end
            if ((state_ff == ST_SCAN) && overlap) begin
               // hold the cell and its geometry for the push-back
               state_in = ST_PUSH;
            end else if (last_cell) begin
               state_in = ST_DONE;
            end else begin
               // advance to the next cell in row-major order
               mem_re   = 1'b1;
               idx_in   = idx_ff + IdxW'(1);
               state_in = ST_SCAN;
               if (col_ff == LastCol) begin
                  col_in = '0;
                  tl_in  = mg_w;
                  tr_in  = ts_w - mg_w;
                  tt_in  = tt_ff + ts_w;
                  tb_in  = tb_ff + ts_w;
               end else begin
                  col_in = col_ff + ColW'(1);
                  tl_in  = tl_ff + ts_w;
                  tr_in  = tr_ff + ts_w;
               end
            end
         end
         ST_PUSH: begin
            dy_in    = push_axis(dy_ff, tt_ff, tb_ff, nt_ff, nb_ff);
            dx_in    = push_axis(dx_ff, tl_ff, tr_ff, nl_ff, nr_ff);
            hit_in   = 1'b1;
            state_in = ST_UPD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               out_x_in     = dx_ff;
               out_y_in     = dy_ff;
               out_hit_in   = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tile_ff      <= twcr_pkg::TILE_SIZE_RESET;
         margin_ff    <= twcr_pkg::SHRINK_MARGIN_RESET;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         tile_ff      <= tile_in;
         margin_ff    <= margin_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff    <= left_in;
      top_ff     <= top_in;
      width_ff   <= width_in;
      height_ff  <= height_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      hit_ff     <= hit_in;
      box_ok_ff  <= box_ok_in;
      tile_ok_ff <= tile_ok_in;
      col_ff     <= col_in;
      nl_ff      <= nl_in;
      nr_ff      <= nr_in;
      nt_ff      <= nt_in;
      nb_ff      <= nb_in;
      tl_ff      <= tl_in;
      tr_ff      <= tr_in;
      tt_ff      <= tt_in;
      tb_ff      <= tb_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_hit_ff <= out_hit_in;
   end

   // wall map: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wall_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= wall_mem[mem_raddr];
      end
   end

`ifndef NO_ASSERTIONS
   a_no_req_in_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_bus.ready)
      else $error("request taken during map clearing pass");

   a_mem_one_port : assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("wall map read and written in one cycle");

   a_push_then_upd : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH) |=> ((state_ff == ST_UPD) && hit_ff))
      else $error("push-back not followed by box update");

   a_col_tracks_idx : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) || (state_ff == ST_UPD)) |->
      (col_ff == ColW'(idx_ff % twcr_pkg::GRID_COLS)))
      else $error("column counter out of step with cell index");

   a_write_rsp : assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_bus.op == twcr_pkg::OP_WRITE)) |=> (rsp_valid_ff && !out_hit_ff))
      else $error("write beat without its response");
`endif

endmodule
